[rtl/statement_char_filter_defines.svh]
// Assertion macros shared by the statement filter checkers.
`ifndef STATEMENT_CHAR_FILTER_DEFINES_SVH
`define STATEMENT_CHAR_FILTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("statement_char_filter check failed");

// Check that cons holds in the cycle after ante.
`define SCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("statement_char_filter check failed");

`endif

[rtl/scf_pkg.sv]
// Types and character constants for the statement character filter.
package scf_pkg;

	localparam logic [7:0] CH_COMMENT = 8'h24;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
		logic       discard;
	} scf_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       statement_end;
		logic       overflow;
	} scf_result_t;

	typedef struct packed {
		logic in_string;
		logic in_escape;
		logic in_line_comment;
		logic prev_was_space;
		logic prev_was_semicolon;
		logic stored_last_semicolon;
	} scf_flags_t;

endpackage

[rtl/scf_in_if.sv]
// Input channel: one source byte per transaction.
interface scf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;
	logic       discard;

	modport source (output valid, output in_char, output end_of_input, output discard,
		input ready);
	modport sink (input valid, input in_char, input end_of_input, input discard,
		output ready);
endinterface

[rtl/scf_out_if.sv]
// Output channel: one filter result per transaction.
interface scf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       statement_end;
	logic       overflow;

	modport source (output valid, output out_char, output char_valid,
		output statement_end, output overflow, input ready);
	modport sink (input valid, input out_char, input char_valid,
		input statement_end, input overflow, output ready);
endinterface

[rtl/scf_core.sv]
// Next-state and result logic of the filter for one source byte.
module scf_core #(
	parameter int MAX_LEN = 256
) (
	input  scf_pkg::scf_item_t                 item,
	input  scf_pkg::scf_flags_t                flags,
	input  logic [$clog2(MAX_LEN+1)-1:0]       count,
	output scf_pkg::scf_flags_t                flags_nxt,
	output logic [$clog2(MAX_LEN+1)-1:0]       count_nxt,
	output scf_pkg::scf_result_t               res
);
	import scf_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	logic [7:0] c;
	logic       at_limit;
	logic       is_ctrl;
	logic       drop;
	logic       red_semi;
	logic       red_space;
	logic       sep;

	assign at_limit = (count == CW'(MAX_LEN));
	assign is_ctrl  = (item.in_char < CH_SPACE) && (item.in_char != CH_NL);

	always_comb begin
		flags_nxt = flags;
		count_nxt = count;
		res       = '0;
		c         = item.in_char;
		drop      = 1'b0;
		red_semi  = 1'b0;
		red_space = 1'b0;
		sep       = 1'b0;

		if (item.end_of_input) begin
			// Close the held statement, appending ';' when missing
			if (count != '0) begin
				if (!flags.stored_last_semicolon) begin
					if (at_limit) begin
						res.overflow = 1'b1;
					end else begin
						res.out_char   = CH_SEMI;
						res.char_valid = 1'b1;
					end
				end
				if (!res.overflow) begin
					res.statement_end         = 1'b1;
					flags_nxt.in_string       = 1'b0;
					flags_nxt.in_escape       = 1'b0;
					flags_nxt.in_line_comment = 1'b0;
				end
			end
			count_nxt                       = '0;
			flags_nxt.stored_last_semicolon = 1'b0;
			flags_nxt.prev_was_semicolon    = 1'b0;
		end else if (!is_ctrl && !item.discard) begin
			// Update the string, comment and collapse modes
			priority if (flags.in_string) begin
				if (c == CH_BSLASH) begin
					flags_nxt.in_escape = !flags.in_escape;
				end else if (c == CH_QUOTE) begin
					flags_nxt.in_string = flags.in_escape;
					flags_nxt.in_escape = 1'b0;
				end else begin
					flags_nxt.in_escape = 1'b0;
				end
				flags_nxt.prev_was_space     = 1'b0;
				flags_nxt.prev_was_semicolon = 1'b0;
			end else if (flags.in_line_comment) begin
				if (c == CH_NL) begin
					flags_nxt.in_line_comment = 1'b0;
				end
				drop = 1'b1;
			end else if (((c == CH_SPACE) || (c == CH_NL)) && (count == '0)) begin
				drop = 1'b1;
			end else if (c == CH_COMMENT) begin
				flags_nxt.in_line_comment = 1'b1;
				drop = 1'b1;
			end else begin
				if (c == CH_QUOTE) begin
					flags_nxt.in_string = 1'b1;
				end else if (c == CH_NL) begin
					c = CH_SPACE;
				end
				red_space = (count != '0) && (c == CH_SPACE) && flags.prev_was_space;
				red_semi  = (c == CH_SEMI) && flags.prev_was_semicolon;
				flags_nxt.prev_was_space     = (c == CH_SPACE);
				flags_nxt.prev_was_semicolon = (c == CH_SEMI);
				drop = red_space || red_semi;
			end

			// Emit the kept byte, or flag overflow at the length limit
			if (!drop) begin
				if (at_limit) begin
					res.overflow = 1'b1;
				end else begin
					res.out_char   = c;
					res.char_valid = 1'b1;
					count_nxt      = count + 1'b1;
					flags_nxt.stored_last_semicolon = (c == CH_SEMI);
					sep = (!flags_nxt.in_string && !flags_nxt.in_line_comment &&
						(c == CH_SEMI) && !red_semi) ||
						(flags_nxt.in_string && (c == CH_NL));
					if (sep) begin
						res.statement_end               = 1'b1;
						count_nxt                       = '0;
						flags_nxt.stored_last_semicolon = 1'b0;
						flags_nxt.in_string             = 1'b0;
						flags_nxt.in_escape             = 1'b0;
						flags_nxt.in_line_comment       = 1'b0;
					end
				end
			end
		end
	end
endmodule

[rtl/statement_char_filter.sv]
// Top level of the statement character filter.
//
// Cleans a source byte stream for a statement parser and returns exactly one
// result per input transaction. An accepted byte is held in an input register,
// where the filter logic reads it together with the string, escape, comment
// and collapse flags and the statement length count; the result then lands
// in an output register. Throughput is one byte per cycle when the output is
// not stalled. Backpressure on the output stalls both registers together.
// MAX_LEN sets the statement length limit (2 to 4096 bytes).
module statement_char_filter #(
	parameter int MAX_LEN = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	scf_in_if.sink    in_ch,
	scf_out_if.source out_ch
);
	import scf_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	logic        valid_s1;
	scf_item_t   item_s1;
	scf_flags_t  flags_q;
	scf_flags_t  flags_nxt;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	scf_result_t res;
	scf_result_t res_q;
	logic        out_valid_q;
	logic        advance;
	logic        accept;

	// Move the pipeline whenever the output register is free or being taken
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	// Hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.in_char      <= in_ch.in_char;
			item_s1.end_of_input <= in_ch.end_of_input;
			item_s1.discard      <= in_ch.discard;
		end
	end

	scf_core #(
		.MAX_LEN(MAX_LEN)
	) u_core (
		.item     (item_s1),
		.flags    (flags_q),
		.count    (count_q),
		.flags_nxt(flags_nxt),
		.count_nxt(count_nxt),
		.res      (res)
	);

	// Advance the filter state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				flags_q <= flags_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_char      = res_q.out_char;
	assign out_ch.char_valid    = res_q.char_valid;
	assign out_ch.statement_end = res_q.statement_end;
	assign out_ch.overflow      = res_q.overflow;
endmodule

[rtl/scf_checker.sv]
// Port-level checks on the statement character filter, bound to its top level.
`include "statement_char_filter_defines.svh"

module scf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       statement_end,
	input logic       overflow
);
	import scf_pkg::*;

	// A stalled result stays offered
	`SCF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// An empty result carries a zero byte
	`SCF_ASSERT_NOW(a_empty_zero, clk, arst_n, out_valid && !char_valid, out_char == 8'h00)

	// Overflow drops the byte and never ends a statement
	`SCF_ASSERT_NOW(a_ovf_drop, clk, arst_n, out_valid && overflow,
		!char_valid && !statement_end)

	// No control byte other than newline gets through
	`SCF_ASSERT_NOW(a_no_ctrl, clk, arst_n, out_valid && char_valid,
		(out_char >= CH_SPACE) || (out_char == CH_NL))

	// A kept newline comes only from a string and ends the statement
	`SCF_ASSERT_NOW(a_nl_ends, clk, arst_n, out_valid && char_valid && (out_char == CH_NL),
		statement_end)
endmodule

bind statement_char_filter scf_checker u_scf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_char     (out_ch.out_char),
	.char_valid   (out_ch.char_valid),
	.statement_end(out_ch.statement_end),
	.overflow     (out_ch.overflow)
);

[sim/scf_result_compare.sv]
// Predicts statement filter results from input transactions and compares them.
`timescale 1ns / 1ps

module scf_result_compare #(
	parameter int LEN_LIMIT = 256
) (
	input  logic clk,
	input  logic arst_n,
	scf_in_if    in_ch,
	scf_out_if   out_ch,
	output int   errors,
	output int   pending,
	output int   items_seen,
	output int   results_seen,
	output int   end_count,
	output int   ovf_count
);
	import scf_pkg::*;

	// Filter state as the block should hold it
	logic        in_str;
	logic        in_esc;
	logic        in_cmt;
	logic        prev_sp;
	logic        prev_semi;
	logic        last_semi;
	int unsigned held;

	scf_result_t expected_results[$];
	scf_item_t   item;
	scf_result_t got;
	scf_result_t want;

	// Leave string, escape and comment modes
	function automatic void clear_modes();
		in_str = 1'b0;
		in_esc = 1'b0;
		in_cmt = 1'b0;
	endfunction

	// Apply one source transaction to the filter state and return its result
	function automatic scf_result_t filter_step(scf_item_t it);
		scf_result_t r;
		logic [7:0]  c;
		logic        drop;
		logic        dup_semi;
		logic        dup_space;
		logic        sep;
		r = '0;
		c = it.in_char;
		drop = 1'b0;
		dup_semi = 1'b0;
		if (it.end_of_input) begin
			// Close the statement, appending ';' unless it already ends in one
			if (held > 0) begin
				if (!last_semi) begin
					if (held >= LEN_LIMIT) begin
						r.overflow = 1'b1;
					end else begin
						r.out_char = CH_SEMI;
						r.char_valid = 1'b1;
						held++;
					end
				end
				if (!r.overflow) begin
					r.statement_end = 1'b1;
					clear_modes();
				end
			end
			held = 0;
			last_semi = 1'b0;
			prev_semi = 1'b0;
		end else if (!(c < CH_SPACE && c != CH_NL) && !it.discard) begin
			if (in_str) begin
				// Track escapes and the closing quote
				if (c == CH_BSLASH) begin
					in_esc = !in_esc;
				end else if (c == CH_QUOTE) begin
					in_str = in_esc;
					in_esc = 1'b0;
				end else begin
					in_esc = 1'b0;
				end
				prev_sp = 1'b0;
				prev_semi = 1'b0;
			end else if (in_cmt) begin
				if (c == CH_NL)
					in_cmt = 1'b0;
				drop = 1'b1;
			end else if ((c == CH_SPACE || c == CH_NL) && held == 0) begin
				drop = 1'b1;
			end else if (c == CH_COMMENT) begin
				in_cmt = 1'b1;
				drop = 1'b1;
			end else begin
				// Fold newlines into spaces and collapse repeats
				if (c == CH_QUOTE)
					in_str = 1'b1;
				else if (c == CH_NL)
					c = CH_SPACE;
				dup_space = (held > 0) && (c == CH_SPACE) && prev_sp;
				dup_semi = (c == CH_SEMI) && prev_semi;
				prev_sp = (c == CH_SPACE);
				prev_semi = (c == CH_SEMI);
				drop = dup_space || dup_semi;
			end

			// Keep the byte, or flag overflow when the statement is full
			if (!drop) begin
				if (held >= LEN_LIMIT) begin
					r.overflow = 1'b1;
				end else begin
					r.out_char = c;
					r.char_valid = 1'b1;
					held++;
					last_semi = (c == CH_SEMI);
					sep = (!in_str && !in_cmt && c == CH_SEMI && !dup_semi)
						|| (in_str && c == CH_NL);
					if (sep) begin
						r.statement_end = 1'b1;
						held = 0;
						last_semi = 1'b0;
						clear_modes();
					end
				end
			end
		end
		return r;
	endfunction

	// Count a failure and report the first few
	task automatic log_failure(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// Predict on each accepted input, compare on each accepted output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_modes();
			prev_sp = 1'b0;
			prev_semi = 1'b0;
			last_semi = 1'b0;
			held = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				item.in_char = in_ch.in_char;
				item.end_of_input = in_ch.end_of_input;
				item.discard = in_ch.discard;
				expected_results.push_back(filter_step(item));
				items_seen++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got.out_char = out_ch.out_char;
				got.char_valid = out_ch.char_valid;
				got.statement_end = out_ch.statement_end;
				got.overflow = out_ch.overflow;
				results_seen++;
				if (got.statement_end === 1'b1)
					end_count++;
				if (got.overflow === 1'b1)
					ovf_count++;
				if (expected_results.size() == 0) begin
					log_failure($sformatf("result with nothing pending: char %02h valid %0b end %0b ovf %0b",
						got.out_char, got.char_valid, got.statement_end, got.overflow));
				end else begin
					want = expected_results.pop_front();
					if (got.out_char !== want.out_char || got.char_valid !== want.char_valid
						|| got.statement_end !== want.statement_end
						|| got.overflow !== want.overflow) begin
						log_failure($sformatf({"mismatch: expected char %02h valid %0b end %0b ovf %0b,",
							" got char %02h valid %0b end %0b ovf %0b"},
							want.out_char, want.char_valid, want.statement_end, want.overflow,
							got.out_char, got.char_valid, got.statement_end, got.overflow));
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

[sim/statement_char_filter_test.sv]
// Stimulus and verdict for the statement character filter.
`timescale 1ns / 1ps

module statement_char_filter_test;
	import scf_pkg::*;

	localparam int LEN_LIMIT = 256;
	localparam int ITEM_TARGET = 1250;
	localparam int HOLD_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	bit   hold_off_req;
	int   sent;

	int errors;
	int pending;
	int items_seen;
	int results_seen;
	int end_count;
	int ovf_count;

	scf_in_if  in_ch();
	scf_out_if out_ch();

	statement_char_filter #(.MAX_LEN(LEN_LIMIT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	scf_result_compare #(.LEN_LIMIT(LEN_LIMIT)) result_cmp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.errors       (errors),
		.pending      (pending),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.end_count    (end_count),
		.ovf_count    (ovf_count)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("statement_char_filter_test: errors");
		$finish;
	end

	// Drive ready: random stalls, or a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	// Offer one transaction, idling at random first, and hold until accepted
	task automatic send(input logic [7:0] c, input logic eoi = 1'b0, input logic disc = 1'b0);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_char <= c;
		in_ch.end_of_input <= eoi;
		in_ch.discard <= disc;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (eoi || !(disc || (c < CH_SPACE && c != CH_NL)))
			sent++;
	endtask

	task automatic send_eoi();
		send(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i]);
	endtask

	function automatic logic [7:0] letter();
		return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
	endfunction

	// Source text byte, weighted toward letters
	function automatic logic [7:0] text_char();
		unique case ($urandom_range(0, 19))
			0: return CH_SPACE;
			1: return CH_NL;
			2: return CH_BSLASH;
			3: return CH_QUOTE;
			4: return CH_COMMENT;
			5: return CH_SEMI;
			6: return 8'($urandom_range(8'h21, 8'h7E));
			7: return 8'($urandom_range(8'h80, 8'hFF));
			default: return letter();
		endcase
	endfunction

	// Byte inside a string literal
	function automatic logic [7:0] string_char();
		unique case ($urandom_range(0, 9))
			5: return CH_BSLASH;
			6: return CH_QUOTE;
			7: return CH_SEMI;
			8: return CH_SPACE;
			9: return CH_NL;
			default: return letter();
		endcase
	endfunction

	// Statement near, at or past the length limit
	task automatic send_long(input bit semi_tail, input int n);
		if (semi_tail) begin
			// String fills the statement exactly, last byte ';'
			send(CH_QUOTE);
			for (int i = 0; i < LEN_LIMIT - 2; i++)
				send(letter());
			send(CH_SEMI);
		end else begin
			for (int i = 0; i < n; i++)
				send(letter());
		end
		send_eoi();
	endtask

	// One random sequence: mostly well-formed statements, some noise
	task automatic send_sequence();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		n = $urandom_range(1, 24);
		if (kind < 55) begin
			// Plain statement
			for (int i = 0; i < n; i++)
				send(text_char());
			if ($urandom_range(0, 2) != 0)
				send(CH_SEMI);
			else
				send_eoi();
		end else if (kind < 72) begin
			// Statement holding a string with escapes
			send(letter());
			send(CH_QUOTE);
			for (int i = 0; i < n; i++)
				send(string_char());
			send(CH_QUOTE);
			send(CH_SEMI);
		end else if (kind < 82) begin
			// Line comment
			send(CH_COMMENT);
			for (int i = 0; i < n; i++)
				send(text_char());
			send(CH_NL);
		end else if (kind < 88) begin
			// Bytes dropped after a parse error
			for (int i = 0; i < n / 4 + 1; i++)
				send(text_char(), 1'b0, 1'b1);
			send_eoi();
		end else if (kind < 98) begin
			// Raw noise on every field
			for (int i = 0; i < 8; i++)
				send(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
					$urandom_range(0, 7) == 0);
		end else begin
			send_long($urandom_range(0, 1), $urandom_range(LEN_LIMIT - 3, LEN_LIMIT + 6));
		end
	endtask

	// Reset, stimulus, drain and verdict
	initial begin
		in_ch.valid <= 1'b0;
		in_ch.in_char <= 8'h00;
		in_ch.end_of_input <= 1'b0;
		in_ch.discard <= 1'b0;
		arst_n <= 1'b0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Control bytes and leading blanks
		send(8'h00);
		send(8'h1F);
		send(CH_SPACE);
		send(CH_NL);
		// Collapsed spaces, newline folded to space
		send_text("A  \n");
		// String with ';', escaped quote and escaped backslash, then a repeated ';'
		send_text("\";\\\"\\\\\";;");
		// Comment hides ';' until newline
		send_text("$;\n");
		// Newline inside a string ends the statement
		send(8'hFF);
		send(CH_QUOTE);
		send(CH_NL);
		// Discarded byte, end of input with nothing held, then appended ';'
		send(8'h80, 1'b0, 1'b1);
		send_eoi();
		send(letter());
		send_eoi();

		// Fill to the limit while the receiver holds off
		hold_off_req = 1'b1;
		send_long(1'b0, LEN_LIMIT);
		send_long(1'b1, 0);

		// Random sequences, with one stretch free of idling
		while (sent < ITEM_TARGET) begin
			calm = (sent >= 900 && sent < 1100);
			send_sequence();
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;
		@(posedge clk);

		// Drain the pipeline
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d transactions (%0d not ignored), checked %0d results.",
			items_seen, sent, results_seen);
		$display("Saw %0d statement ends and %0d overflows, %0d failures.",
			end_count, ovf_count, errors);
		if (errors == 0 && pending == 0)
			$display("statement_char_filter_test: clean");
		else
			$display("statement_char_filter_test: errors");
		$finish;
	end

endmodule
